// ===== rtl/temporal_grayscale_frame_detector_core_defines.svh =====
// Assertion macros used by the detector core.
`ifndef TEMPORAL_GRAYSCALE_FRAME_DETECTOR_CORE_DEFINES_SVH
`define TEMPORAL_GRAYSCALE_FRAME_DETECTOR_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TGFD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TGFD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/tgfd_pkg.sv =====
package tgfd_pkg;

    // Default frame geometry.
    localparam int FRAME_ROWS_DEF = 64;
    localparam int ROW_BYTES_DEF  = 17;

    // Field widths.
    localparam int MODE_W  = 2;
    localparam int BYTE_W  = 8;
    localparam int TIME_W  = 48;
    localparam int RIDX_W  = 11;
    localparam int DIFF_W  = 14;
    localparam int US_W    = 24;
    localparam int CIDX_W  = 3;
    localparam int CDATA_W = 24;

    // Input item modes.
    localparam logic [MODE_W-1:0] MODE_FRAME = 2'd0;
    localparam logic [MODE_W-1:0] MODE_TICK  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

    // Result kinds.
    localparam logic [MODE_W-1:0] KIND_FRAME = 2'd0;
    localparam logic [MODE_W-1:0] KIND_TICK  = 2'd1;
    localparam logic [MODE_W-1:0] KIND_READ  = 2'd2;

    // Register indexes.
    localparam logic [CIDX_W-1:0] REG_MIN_PLANE = 3'd0;
    localparam logic [CIDX_W-1:0] REG_SCENE_CUT = 3'd1;
    localparam logic [CIDX_W-1:0] REG_MARGIN    = 3'd2;
    localparam logic [CIDX_W-1:0] REG_PAIR_MAX  = 3'd3;
    localparam logic [CIDX_W-1:0] REG_CYCLE_MAX = 3'd4;
    localparam logic [CIDX_W-1:0] REG_HOLD      = 3'd5;

    // Register reset values.
    localparam logic [DIFF_W-1:0] MIN_PLANE_RST = 14'd512;
    localparam logic [DIFF_W-1:0] SCENE_CUT_RST = 14'd1024;
    localparam logic [DIFF_W-1:0] MARGIN_RST    = 14'd192;
    localparam logic [US_W-1:0]   PAIR_MAX_RST  = 24'd70000;
    localparam logic [US_W-1:0]   CYCLE_MAX_RST = 24'd140000;
    localparam logic [US_W-1:0]   HOLD_RST      = 24'd750000;

endpackage

// ===== rtl/tgfd_if.sv =====
// Input item channel.
interface tgfd_in_if;
    logic                         valid;
    logic                         ready;
    logic [tgfd_pkg::MODE_W-1:0]  mode;
    logic [tgfd_pkg::BYTE_W-1:0]  pixel_byte;
    logic                         frame_end;
    logic                         display_on;
    logic                         gray_hint;
    logic [tgfd_pkg::TIME_W-1:0]  time_us;
    logic [tgfd_pkg::RIDX_W-1:0]  read_index;
    logic                         read_alternate;

    modport source (output valid, mode, pixel_byte, frame_end, display_on, gray_hint,
                    time_us, read_index, read_alternate, input ready);
    modport sink   (input valid, mode, pixel_byte, frame_end, display_on, gray_hint,
                    time_us, read_index, read_alternate, output ready);
endinterface

// Result channel.
interface tgfd_out_if;
    logic                         valid;
    logic                         ready;
    logic [tgfd_pkg::MODE_W-1:0]  kind;
    logic [tgfd_pkg::BYTE_W-1:0]  read_byte;
    logic                         gray_active;
    logic                         expired;
    logic [tgfd_pkg::DIFF_W-1:0]  adjacent_bits;

    modport source (output valid, kind, read_byte, gray_active, expired, adjacent_bits,
                    input ready);
    modport sink   (input valid, kind, read_byte, gray_active, expired, adjacent_bits,
                    output ready);
endinterface

// Register write channel.
interface tgfd_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [tgfd_pkg::CIDX_W-1:0]   index;
    logic [tgfd_pkg::CDATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/tgfd_ram.sv =====
module tgfd_ram #(
    parameter int DEPTH = tgfd_pkg::FRAME_ROWS_DEF * tgfd_pkg::ROW_BYTES_DEF,
    parameter int AW    = 11,
    parameter int DW    = tgfd_pkg::BYTE_W
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== rtl/temporal_grayscale_frame_detector_core.sv =====
// Channel   Dir  Beat contents
// i_in      in   mode, pixel_byte, frame_end, display_on, gray_hint, time_us, read_index,
//                read_alternate
// o_out     out  kind, read_byte, gray_active, expired, adjacent_bits
// i_cfg     in   index, data (register write, always ready)
//
// A frame byte is accepted while the sequencer is idle. A frame end runs two sweeps:
// one sweep over the frame memories counts differing bits, a second sweep rewrites them.
// A tick runs the tick step, plus a rewrite sweep when it ends grayscale with a previous frame.
// A read goes through the registered port of a pending image memory, then the wait and emit steps.
// Reset is synchronous and clears control state only; the image memories need no clearing.
// A result waits in the output register; input beats stall only while the sequencer is busy.
`include "temporal_grayscale_frame_detector_core_defines.svh"

module temporal_grayscale_frame_detector_core #(
    parameter int FRAME_ROWS = tgfd_pkg::FRAME_ROWS_DEF,
    parameter int ROW_BYTES  = tgfd_pkg::ROW_BYTES_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    tgfd_in_if.sink       i_in,
    tgfd_out_if.source    o_out,
    tgfd_cfg_if.sink      i_cfg
);

    localparam int FB  = FRAME_ROWS * ROW_BYTES;
    localparam int AW  = (FB > 1) ? $clog2(FB) : 1;
    localparam int PW  = $clog2(FB + 1);
    localparam int CW  = $clog2(8 * FB + 1);
    localparam int XW  = ((CW > tgfd_pkg::DIFF_W) ? CW : tgfd_pkg::DIFF_W) + 2;
    localparam int BW  = tgfd_pkg::BYTE_W;
    localparam int TW  = tgfd_pkg::TIME_W;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_DIFF   = 8'b0000_0010,
        S_JUDGE  = 8'b0000_0100,
        S_APPLY  = 8'b0000_1000,
        S_COPY   = 8'b0001_0000,
        S_TICK   = 8'b0010_0000,
        S_RDWAIT = 8'b0100_0000,
        S_EMIT   = 8'b1000_0000
    } t_state;

    typedef enum logic [1:0] {A_KEEP, A_CUR, A_PREV} t_asrc;
    typedef enum logic [1:0] {P_NONE, P_CUR, P_B, P_PREV} t_psrc;

    // Which memories the rewrite sweep updates and from where.
    typedef struct packed {
        t_asrc a_src;
        logic  b_cur;
        logic  older_wr;
        logic  prev_wr;
        t_psrc pri_src;
        logic  alt_wr;
    } t_copy;

    function automatic logic [3:0] popcount8(input logic [BW-1:0] v);
        logic [3:0] n;
        n = '0;
        for (int k = 0; k < BW; k++) begin
            n = n + 4'(v[k]);
        end
        return n;
    endfunction

    t_state r_state;

    // Configuration registers.
    logic [tgfd_pkg::DIFF_W-1:0] r_min_plane, r_scene_cut, r_margin;
    logic [tgfd_pkg::US_W-1:0]   r_pair_max, r_cycle_max, r_hold;

    // Tracking state.
    logic          r_prev_valid, r_older_valid, r_gray, r_reseed, r_latest_b, r_ev_valid;
    logic [TW-1:0] r_prev_time, r_older_time, r_ev_time;
    logic [PW-1:0] r_pos, r_len;
    logic [CW-1:0] r_acc_prev, r_acc_old, r_acc_a, r_acc_b;

    // Beat fields held for the multi-cycle work.
    logic [TW-1:0] r_t;
    logic          r_on, r_hint, r_ralt, r_rin;

    // Sweep counters.
    logic [PW-1:0] r_addr;
    logic          r_vld;
    logic [AW-1:0] r_addr_d;

    // Registered comparisons of the judge step.
    logic r_hold_ok, r_pair_ok, r_cycle_ok, r_aba_ok, r_new_plane;
    logic r_confident, r_far_both, r_pick_b, r_da_ge_min;

    t_copy r_cp, n_cp;

    // Pending result and output register.
    logic [tgfd_pkg::MODE_W-1:0] r_res_kind, r_out_kind;
    logic [BW-1:0]               r_res_byte, r_out_byte;
    logic                        r_res_gray, r_out_gray, r_res_exp, r_out_exp;
    logic [tgfd_pkg::DIFF_W-1:0] r_res_adj, r_out_adj;
    logic                        r_out_valid;

    // Memory ports.
    logic [BW-1:0] q_cur, q_prv, q_old, q_pla, q_plb, q_pri, q_alt;
    logic          we_cur, we_prv, we_old, we_pla, we_plb, we_pri, we_alt;
    logic [BW-1:0] wd_pri, new_a, new_b, cur_m;
    logic [AW-1:0] sweep_raddr, pend_raddr;
    logic [XW-1:0] ridx_w;

    logic in_acc, issue, do_wr, cur_room;
    logic [CW-1:0] adj;

    // Next tracking values at the apply and tick steps.
    logic          n_prev_valid, n_older_valid, n_gray, n_reseed, n_latest_b, n_ev_valid;
    logic [TW-1:0] n_prev_time, n_older_time, n_ev_time;
    logic          n_exp;

    assign in_acc     = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;

    assign o_out.valid         = r_out_valid;
    assign o_out.kind          = r_out_kind;
    assign o_out.read_byte     = r_out_byte;
    assign o_out.gray_active   = r_out_gray;
    assign o_out.expired       = r_out_exp;
    assign o_out.adjacent_bits = r_out_adj;

    assign cur_room    = (r_pos < PW'(FB));
    assign issue       = (r_addr != PW'(FB));
    assign sweep_raddr = r_addr[AW-1:0];
    assign ridx_w      = XW'(i_in.read_index);
    assign pend_raddr  = (r_state == S_IDLE) ? ridx_w[AW-1:0] : sweep_raddr;
    assign adj         = r_prev_valid ? r_acc_prev : '0;

    // Bytes past the received length of a short frame read as zero.
    assign cur_m = (PW'(r_addr_d) < r_len) ? q_cur : '0;

    // Rewrite data for the current sweep address.
    always_comb begin
        case (r_cp.a_src)
            A_CUR:   new_a = cur_m;
            A_PREV:  new_a = q_prv;
            default: new_a = q_pla;
        endcase
        new_b = r_cp.b_cur ? cur_m : q_plb;
        case (r_cp.pri_src)
            P_CUR:   wd_pri = cur_m;
            P_B:     wd_pri = new_b;
            P_PREV:  wd_pri = q_prv;
            default: wd_pri = q_pri;
        endcase
    end

    assign do_wr  = (r_state == S_COPY) && r_vld;
    assign we_cur = in_acc && (i_in.mode == tgfd_pkg::MODE_FRAME) && cur_room;
    assign we_pla = do_wr && (r_cp.a_src != A_KEEP);
    assign we_plb = do_wr && r_cp.b_cur;
    assign we_old = do_wr && r_cp.older_wr;
    assign we_prv = do_wr && r_cp.prev_wr;
    assign we_pri = do_wr && (r_cp.pri_src != P_NONE);
    assign we_alt = do_wr && r_cp.alt_wr;

    tgfd_ram #(.DEPTH(FB), .AW(AW), .DW(BW)) u_cur (
        .i_clk(i_clk), .i_we(we_cur), .i_waddr(r_pos[AW-1:0]), .i_wdata(i_in.pixel_byte),
        .i_raddr(sweep_raddr), .o_rdata(q_cur));
    tgfd_ram #(.DEPTH(FB), .AW(AW), .DW(BW)) u_prv (
        .i_clk(i_clk), .i_we(we_prv), .i_waddr(r_addr_d), .i_wdata(cur_m),
        .i_raddr(sweep_raddr), .o_rdata(q_prv));
    tgfd_ram #(.DEPTH(FB), .AW(AW), .DW(BW)) u_old (
        .i_clk(i_clk), .i_we(we_old), .i_waddr(r_addr_d), .i_wdata(q_prv),
        .i_raddr(sweep_raddr), .o_rdata(q_old));
    tgfd_ram #(.DEPTH(FB), .AW(AW), .DW(BW)) u_pla (
        .i_clk(i_clk), .i_we(we_pla), .i_waddr(r_addr_d), .i_wdata(new_a),
        .i_raddr(sweep_raddr), .o_rdata(q_pla));
    tgfd_ram #(.DEPTH(FB), .AW(AW), .DW(BW)) u_plb (
        .i_clk(i_clk), .i_we(we_plb), .i_waddr(r_addr_d), .i_wdata(new_b),
        .i_raddr(sweep_raddr), .o_rdata(q_plb));
    tgfd_ram #(.DEPTH(FB), .AW(AW), .DW(BW)) u_pri (
        .i_clk(i_clk), .i_we(we_pri), .i_waddr(r_addr_d), .i_wdata(wd_pri),
        .i_raddr(pend_raddr), .o_rdata(q_pri));
    tgfd_ram #(.DEPTH(FB), .AW(AW), .DW(BW)) u_alt (
        .i_clk(i_clk), .i_we(we_alt), .i_waddr(r_addr_d), .i_wdata(new_a),
        .i_raddr(pend_raddr), .o_rdata(q_alt));

    // Decision rules of the apply step and the tick step.
    always_comb begin
        n_prev_valid  = r_prev_valid;
        n_older_valid = r_older_valid;
        n_gray        = r_gray;
        n_reseed      = r_reseed;
        n_latest_b    = r_latest_b;
        n_ev_valid    = r_ev_valid;
        n_ev_time     = r_ev_time;
        n_prev_time   = r_prev_time;
        n_older_time  = r_older_time;
        n_cp          = '{a_src: A_KEEP, b_cur: 1'b0, older_wr: 1'b0, prev_wr: 1'b0,
                          pri_src: P_NONE, alt_wr: 1'b0};
        n_exp         = r_gray && r_ev_valid && (r_t >= r_ev_time) &&
                        ((r_t - r_ev_time) > TW'(r_hold));
        if (r_state == S_TICK) begin
            if (n_exp) begin
                n_gray        = 1'b0;
                n_reseed      = 1'b0;
                n_ev_valid    = 1'b0;
                n_older_valid = 1'b0;
                if (r_prev_valid) begin
                    n_cp.pri_src = P_PREV;
                end
            end
        end else begin
            if (!r_on) begin
                n_gray        = 1'b0;
                n_reseed      = 1'b0;
                n_ev_valid    = 1'b0;
                n_prev_valid  = 1'b0;
                n_older_valid = 1'b0;
            end else if (!r_prev_valid || (adj != '0)) begin
                if (r_gray && !r_hint && !r_hold_ok) begin
                    n_gray = 1'b0;
                end
                if (n_gray) begin
                    // Nearest-plane tracking with reseed after a scene cut.
                    if (r_hint && r_reseed) begin
                        if (r_da_ge_min) begin
                            n_cp.b_cur = 1'b1;
                            n_latest_b = 1'b1;
                            n_reseed   = 1'b0;
                        end else begin
                            n_cp.a_src = A_CUR;
                            n_cp.b_cur = 1'b1;
                        end
                        n_ev_valid = 1'b1;
                        n_ev_time  = r_t;
                    end else if (r_hint && r_far_both) begin
                        n_cp.a_src = A_CUR;
                        n_cp.b_cur = 1'b1;
                        n_latest_b = 1'b0;
                        n_reseed   = 1'b1;
                        n_ev_valid = 1'b1;
                        n_ev_time  = r_t;
                    end else if (r_hint || r_confident) begin
                        if (r_pick_b) begin
                            n_cp.b_cur = 1'b1;
                        end else begin
                            n_cp.a_src = A_CUR;
                        end
                        if (r_hint || (r_pick_b != r_latest_b)) begin
                            n_ev_valid = 1'b1;
                            n_ev_time  = r_t;
                        end
                        n_latest_b = r_pick_b;
                    end
                end else if ((r_hint && r_prev_valid && r_new_plane) ||
                             (r_new_plane && r_prev_valid && r_older_valid && r_pair_ok &&
                              r_cycle_ok && r_aba_ok)) begin
                    // Grayscale starts from the previous and current frames.
                    n_cp.a_src = A_PREV;
                    n_cp.b_cur = 1'b1;
                    n_latest_b = 1'b1;
                    n_gray     = 1'b1;
                    n_reseed   = 1'b0;
                    n_ev_valid = 1'b1;
                    n_ev_time  = r_t;
                end
                if (r_prev_valid) begin
                    n_cp.older_wr = 1'b1;
                    n_older_time  = r_prev_time;
                    n_older_valid = 1'b1;
                end
                n_cp.prev_wr = 1'b1;
                n_prev_time  = r_t;
                n_prev_valid = 1'b1;
            end
            if (n_gray) begin
                n_cp.alt_wr  = 1'b1;
                n_cp.pri_src = P_B;
            end else begin
                n_cp.pri_src = P_CUR;
            end
        end
    end

    // Sequencer, tracking state and result registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_min_plane   <= tgfd_pkg::MIN_PLANE_RST;
            r_scene_cut   <= tgfd_pkg::SCENE_CUT_RST;
            r_margin      <= tgfd_pkg::MARGIN_RST;
            r_pair_max    <= tgfd_pkg::PAIR_MAX_RST;
            r_cycle_max   <= tgfd_pkg::CYCLE_MAX_RST;
            r_hold        <= tgfd_pkg::HOLD_RST;
            r_prev_valid  <= 1'b0;
            r_older_valid <= 1'b0;
            r_gray        <= 1'b0;
            r_reseed      <= 1'b0;
            r_latest_b    <= 1'b0;
            r_ev_valid    <= 1'b0;
            r_prev_time   <= '0;
            r_older_time  <= '0;
            r_ev_time     <= '0;
            r_pos         <= '0;
            r_len         <= '0;
            r_acc_prev    <= '0;
            r_acc_old     <= '0;
            r_acc_a       <= '0;
            r_acc_b       <= '0;
            r_addr        <= '0;
            r_vld         <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            // Register writes.
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    tgfd_pkg::REG_MIN_PLANE: r_min_plane <= i_cfg.data[tgfd_pkg::DIFF_W-1:0];
                    tgfd_pkg::REG_SCENE_CUT: r_scene_cut <= i_cfg.data[tgfd_pkg::DIFF_W-1:0];
                    tgfd_pkg::REG_MARGIN:    r_margin    <= i_cfg.data[tgfd_pkg::DIFF_W-1:0];
                    tgfd_pkg::REG_PAIR_MAX:  r_pair_max  <= i_cfg.data;
                    tgfd_pkg::REG_CYCLE_MAX: r_cycle_max <= i_cfg.data;
                    tgfd_pkg::REG_HOLD:      r_hold      <= i_cfg.data;
                    default: ;
                endcase
            end

            // Output register drains independently of the sequencer.
            if (o_out.valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_t    <= i_in.time_us;
                        r_on   <= i_in.display_on;
                        r_hint <= i_in.gray_hint;
                        r_ralt <= i_in.read_alternate;
                        r_rin  <= (32'(i_in.read_index) < FB);
                        case (i_in.mode)
                            tgfd_pkg::MODE_FRAME: begin
                                if (i_in.frame_end) begin
                                    r_len      <= cur_room ? r_pos + 1'b1 : r_pos;
                                    r_pos      <= '0;
                                    r_addr     <= '0;
                                    r_vld      <= 1'b0;
                                    r_acc_prev <= '0;
                                    r_acc_old  <= '0;
                                    r_acc_a    <= '0;
                                    r_acc_b    <= '0;
                                    r_state    <= S_DIFF;
                                end else if (cur_room) begin
                                    r_pos <= r_pos + 1'b1;
                                end
                            end
                            tgfd_pkg::MODE_TICK: r_state <= S_TICK;
                            tgfd_pkg::MODE_READ: r_state <= S_RDWAIT;
                            default: ;
                        endcase
                    end
                end
                S_DIFF: begin
                    // Count differing bits against the four stores.
                    if (issue) begin
                        r_addr <= r_addr + 1'b1;
                    end
                    r_vld    <= issue;
                    r_addr_d <= sweep_raddr;
                    if (r_vld) begin
                        r_acc_prev <= r_acc_prev + CW'(popcount8(cur_m ^ q_prv));
                        r_acc_old  <= r_acc_old + CW'(popcount8(cur_m ^ q_old));
                        r_acc_a    <= r_acc_a + CW'(popcount8(cur_m ^ q_pla));
                        r_acc_b    <= r_acc_b + CW'(popcount8(cur_m ^ q_plb));
                    end
                    if (!issue && !r_vld) begin
                        r_state <= S_JUDGE;
                    end
                end
                S_JUDGE: begin
                    r_new_plane <= XW'(adj) >= XW'(r_min_plane);
                    r_hold_ok   <= r_ev_valid && (r_t >= r_ev_time) &&
                                   ((r_t - r_ev_time) <= TW'(r_hold));
                    r_pair_ok   <= (r_t >= r_prev_time) &&
                                   ((r_t - r_prev_time) <= TW'(r_pair_max));
                    r_cycle_ok  <= (r_t >= r_older_time) &&
                                   ((r_t - r_older_time) <= TW'(r_cycle_max));
                    r_aba_ok    <= ((XW'(r_acc_old) << 1) + XW'(r_acc_old)) <
                                   (XW'(adj) + XW'(r_margin));
                    r_pick_b    <= r_acc_b < r_acc_a;
                    r_confident <= (r_acc_b < r_acc_a)
                        ? (((XW'(r_acc_b) << 1) + XW'(r_acc_b)) < (XW'(r_acc_a) + XW'(r_margin)))
                        : (((XW'(r_acc_a) << 1) + XW'(r_acc_a)) < (XW'(r_acc_b) + XW'(r_margin)));
                    r_far_both  <= (XW'(r_acc_a) >= XW'(r_scene_cut)) &&
                                   (XW'(r_acc_b) >= XW'(r_scene_cut));
                    r_da_ge_min <= XW'(r_acc_a) >= XW'(r_min_plane);
                    r_state     <= S_APPLY;
                end
                S_APPLY, S_TICK: begin
                    r_prev_valid  <= n_prev_valid;
                    r_older_valid <= n_older_valid;
                    r_gray        <= n_gray;
                    r_reseed      <= n_reseed;
                    r_latest_b    <= n_latest_b;
                    r_ev_valid    <= n_ev_valid;
                    r_ev_time     <= n_ev_time;
                    r_prev_time   <= n_prev_time;
                    r_older_time  <= n_older_time;
                    r_cp          <= n_cp;
                    r_addr        <= '0;
                    r_vld         <= 1'b0;
                    r_res_byte    <= '0;
                    r_res_gray    <= n_gray;
                    if (r_state == S_TICK) begin
                        r_res_kind <= tgfd_pkg::KIND_TICK;
                        r_res_exp  <= n_exp;
                        r_res_adj  <= '0;
                        r_state    <= (n_cp.pri_src != P_NONE) ? S_COPY : S_EMIT;
                    end else begin
                        r_res_kind <= tgfd_pkg::KIND_FRAME;
                        r_res_exp  <= 1'b0;
                        r_res_adj  <= (32'(adj) > 32'd16383) ? 14'h3FFF
                                                             : tgfd_pkg::DIFF_W'(adj);
                        r_state    <= S_COPY;
                    end
                end
                S_COPY: begin
                    // Read at one address, write it back in the next cycle.
                    if (issue) begin
                        r_addr <= r_addr + 1'b1;
                    end
                    r_vld    <= issue;
                    r_addr_d <= sweep_raddr;
                    if (!issue && !r_vld) begin
                        r_state <= S_EMIT;
                    end
                end
                S_RDWAIT: begin
                    r_res_kind <= tgfd_pkg::KIND_READ;
                    r_res_byte <= r_rin ? (r_ralt ? q_alt : q_pri) : '0;
                    r_res_gray <= r_gray;
                    r_res_exp  <= 1'b0;
                    r_res_adj  <= '0;
                    r_state    <= S_EMIT;
                end
                S_EMIT: begin
                    if (!r_out_valid || o_out.ready) begin
                        r_out_valid <= 1'b1;
                        r_out_kind  <= r_res_kind;
                        r_out_byte  <= r_res_byte;
                        r_out_gray  <= r_res_gray;
                        r_out_exp   <= r_res_exp;
                        r_out_adj   <= r_res_adj;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Grayscale tracking always rests on a valid previous frame.
    `TGFD_ASSERT_NOW(a_gray_has_prev, i_clk, i_rst_n, r_gray, r_prev_valid, "gray without previous frame")

    // A frame end always starts the counting sweep with the byte counter cleared.
    `TGFD_ASSERT_NEXT(a_frame_end_sweep, i_clk, i_rst_n, in_acc && (i_in.mode == tgfd_pkg::MODE_FRAME) && i_in.frame_end, (r_state == S_DIFF) && (r_pos == '0), "frame end did not start sweep")

    // A result only appears from the emit step.
    `TGFD_ASSERT_NOW(a_out_from_emit, i_clk, i_rst_n, $rose(r_out_valid), $past(r_state == S_EMIT), "result loaded outside emit")

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import tgfd_pkg::*;

    localparam int FB         = FRAME_ROWS_DEF * ROW_BYTES_DEF;
    localparam int IDLE_LIMIT = 20000;
    localparam int DRAIN_WAIT = 3000;
    localparam int PAT_LEN    = 24;

    typedef logic [7:0] frame_t [FB];

    typedef struct {
        logic [MODE_W-1:0] mode;
        logic [7:0]        pix;
        logic              fe;
        logic              on;
        logic              hint;
        logic [TIME_W-1:0] t;
        logic [RIDX_W-1:0] ridx;
        logic              ralt;
    } item_t;

    typedef struct {
        logic [MODE_W-1:0] kind;
        logic [7:0]        rbyte;
        logic              gray;
        logic              expd;
        logic [DIFF_W-1:0] adj;
    } status_t;

    logic i_clk;
    logic i_rst_n;

    tgfd_in_if  in_if ();
    tgfd_out_if out_if ();
    tgfd_cfg_if cfg_if ();

    temporal_grayscale_frame_detector_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    // Clock generation.
    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    // Predicted detector state and register copies.
    int unsigned       cfg_min_plane, cfg_scene_cut, cfg_margin;
    longint unsigned   cfg_pair_max, cfg_cycle_max, cfg_hold;
    frame_t            fr_cur, fr_prev, fr_old, pl_a, pl_b, pend_pri, pend_alt;
    int unsigned       pos;
    int unsigned       cnt [4];
    bit                prev_v, old_v, gray_on, reseed, latest_b, ev_v;
    longint unsigned   prev_t, old_t, ev_t;
    bit                pri_ok, alt_ok;

    status_t           status_q [$];
    int                errors;
    int                mismatches;
    int                items_sent;
    bit                quiet;
    bit                in_acc_seen;

    // Stimulus pattern store.
    logic [7:0]        pat_a [PAT_LEN];
    logic [7:0]        pat_b [PAT_LEN];
    longint unsigned   cur_t;

    function automatic int unsigned bit_diff(input frame_t x, input frame_t y);
        int unsigned n;
        n = 0;
        for (int i = 0; i < FB; i++) n += $countones(x[i] ^ y[i]);
        return n;
    endfunction

    function automatic void start_gray(input longint unsigned t);
        pl_a = fr_prev;
        pl_b = fr_cur;
        latest_b = 1'b1;
        gray_on = 1'b1;
        reseed = 1'b0;
        ev_v = 1'b1;
        ev_t = t;
    endfunction

    function automatic void track_gray(input bit hint, input longint unsigned t);
        int unsigned da, db, near_cnt, far_cnt;
        bit pick_b, confident, far_both;
        da = cnt[2];
        db = cnt[3];
        pick_b = db < da;
        near_cnt = pick_b ? db : da;
        far_cnt = pick_b ? da : db;
        confident = near_cnt * 3 < far_cnt + cfg_margin;
        far_both = da >= cfg_scene_cut && db >= cfg_scene_cut;
        if (hint && reseed) begin
            if (da >= cfg_min_plane) begin
                pl_b = fr_cur;
                latest_b = 1'b1;
                reseed = 1'b0;
            end else begin
                pl_a = fr_cur;
                pl_b = fr_cur;
            end
            ev_v = 1'b1;
            ev_t = t;
        end else if (hint && far_both) begin
            pl_a = fr_cur;
            pl_b = fr_cur;
            latest_b = 1'b0;
            reseed = 1'b1;
            ev_v = 1'b1;
            ev_t = t;
        end else if (hint || confident) begin
            if (pick_b) pl_b = fr_cur;
            else pl_a = fr_cur;
            if (hint || pick_b != latest_b) begin
                ev_v = 1'b1;
                ev_t = t;
            end
            latest_b = pick_b;
        end
    endfunction

    // Frame end: count differences, update tracking, form pending images.
    function automatic void close_frame(input bit on, input bit hint, input longint unsigned t);
        int unsigned adj;
        bit new_plane, hold;
        for (int i = pos; i < FB; i++) fr_cur[i] = 8'd0;
        pos = 0;
        cnt[0] = prev_v ? bit_diff(fr_cur, fr_prev) : 0;
        cnt[1] = bit_diff(fr_cur, fr_old);
        cnt[2] = bit_diff(fr_cur, pl_a);
        cnt[3] = bit_diff(fr_cur, pl_b);
        adj = cnt[0];
        if (!on) begin
            gray_on = 1'b0;
            reseed = 1'b0;
            ev_v = 1'b0;
            prev_v = 1'b0;
            old_v = 1'b0;
        end else if (!prev_v || adj != 0) begin
            new_plane = adj >= cfg_min_plane;
            hold = ev_v && t >= ev_t && t - ev_t <= cfg_hold;
            if (gray_on && !hint && !hold) gray_on = 1'b0;
            if (gray_on) begin
                track_gray(hint, t);
            end else if (hint && prev_v && new_plane) begin
                start_gray(t);
            end else if (new_plane && prev_v && old_v &&
                         t >= prev_t && t - prev_t <= cfg_pair_max &&
                         t >= old_t && t - old_t <= cfg_cycle_max) begin
                if (cnt[1] * 3 < adj + cfg_margin) start_gray(t);
            end
            if (prev_v) begin
                fr_old = fr_prev;
                old_t = prev_t;
                old_v = 1'b1;
            end
            fr_prev = fr_cur;
            prev_t = t;
            prev_v = 1'b1;
        end
        if (gray_on) begin
            pend_alt = pl_a;
            pend_pri = pl_b;
            alt_ok = 1'b1;
        end else begin
            pend_pri = fr_cur;
        end
        pri_ok = 1'b1;
    endfunction

    // Model update for one accepted input beat, queuing its expected status if it gives one.
    function automatic void predict_status(input item_t it);
        status_t s;
        longint unsigned t;
        bit expd;
        t = it.t;
        s.kind = KIND_FRAME;
        s.rbyte = 8'd0;
        s.expd = 1'b0;
        s.adj = '0;
        if (it.mode == MODE_FRAME) begin
            if (pos < FB) begin
                fr_cur[pos] = it.pix;
                pos++;
            end
            if (it.fe) begin
                close_frame(it.on, it.hint, t);
                s.gray = gray_on;
                s.adj = cnt[0] > 16383 ? 14'h3FFF : cnt[0][DIFF_W-1:0];
                status_q.push_back(s);
            end
        end else if (it.mode == MODE_TICK) begin
            expd = gray_on && ev_v && t >= ev_t && t - ev_t > cfg_hold;
            if (expd) begin
                gray_on = 1'b0;
                reseed = 1'b0;
                ev_v = 1'b0;
                old_v = 1'b0;
                if (prev_v) pend_pri = fr_prev;
            end
            s.kind = KIND_TICK;
            s.gray = gray_on;
            s.expd = expd;
            status_q.push_back(s);
        end else if (it.mode == MODE_READ) begin
            s.kind = KIND_READ;
            if (it.ridx < FB) s.rbyte = it.ralt ? pend_alt[it.ridx] : pend_pri[it.ridx];
            s.gray = gray_on;
            status_q.push_back(s);
        end
    endfunction

    function automatic void model_config(input logic [CIDX_W-1:0] idx,
                                         input logic [CDATA_W-1:0] data);
        case (idx)
            REG_MIN_PLANE: cfg_min_plane = data[DIFF_W-1:0];
            REG_SCENE_CUT: cfg_scene_cut = data[DIFF_W-1:0];
            REG_MARGIN:    cfg_margin = data[DIFF_W-1:0];
            REG_PAIR_MAX:  cfg_pair_max = data;
            REG_CYCLE_MAX: cfg_cycle_max = data;
            REG_HOLD:      cfg_hold = data;
            default: ;
        endcase
    endfunction

    function automatic item_t rand_item();
        item_t it;
        it.mode = MODE_FRAME;
        it.pix = $urandom;
        it.fe = $urandom;
        it.on = $urandom;
        it.hint = $urandom;
        it.t = {$urandom, $urandom};
        it.ridx = $urandom;
        it.ralt = $urandom;
        return it;
    endfunction

    // Send one input beat, with an optional idle burst first.
    task automatic send_item(input item_t it);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.mode <= it.mode;
        in_if.pixel_byte <= it.pix;
        in_if.frame_end <= it.fe;
        in_if.display_on <= it.on;
        in_if.gray_hint <= it.hint;
        in_if.time_us <= it.t;
        in_if.read_index <= it.ridx;
        in_if.read_alternate <= it.ralt;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        predict_status(it);
        items_sent++;
    endtask

    // Send a frame of len bytes taken from a pattern, closed by frame end.
    // Content: 0 pattern A, 1 pattern B, 2 pattern A with a flipped bit, 3 random, 4 zeros.
    task automatic send_frame(input int content, input int len, input bit on, input bit hint,
                              input longint unsigned t);
        item_t it;
        int flip;
        flip = $urandom_range(0, len * 8 - 1);
        for (int i = 0; i < len; i++) begin
            it = rand_item();
            it.mode = MODE_FRAME;
            case (content)
                0: it.pix = pat_a[i % PAT_LEN];
                1: it.pix = pat_b[i % PAT_LEN];
                2: it.pix = pat_a[i % PAT_LEN] ^ ((i == flip / 8) ? (8'd1 << (flip % 8)) : 8'd0);
                3: it.pix = $urandom;
                default: it.pix = 8'd0;
            endcase
            it.fe = (i == len - 1);
            it.on = on;
            it.hint = hint;
            it.t = t;
            send_item(it);
        end
    endtask

    task automatic send_read(input int idx, input bit alt);
        item_t it;
        it = rand_item();
        it.mode = MODE_READ;
        it.ridx = idx;
        it.ralt = alt && alt_ok;
        send_item(it);
    endtask

    task automatic send_tick(input longint unsigned t);
        item_t it;
        it = rand_item();
        it.mode = MODE_TICK;
        it.t = t;
        send_item(it);
    endtask

    task automatic wait_idle();
        in_if.valid <= 1'b0;
        while (status_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    // Write all registers once the block has drained; index past the list is also written.
    task automatic set_config(input logic [CDATA_W-1:0] v0, input logic [CDATA_W-1:0] v1,
                              input logic [CDATA_W-1:0] v2, input logic [CDATA_W-1:0] v3,
                              input logic [CDATA_W-1:0] v4, input logic [CDATA_W-1:0] v5);
        logic [CDATA_W-1:0] vals [7];
        wait_idle();
        vals = '{v0, v1, v2, v3, v4, v5, $urandom};
        for (int i = 0; i < 7; i++) begin
            cfg_if.valid <= 1'b1;
            cfg_if.index <= i;
            cfg_if.data <= vals[i];
            @(posedge i_clk);
            while (!cfg_if.ready) @(posedge i_clk);
            model_config(i, vals[i]);
        end
        cfg_if.valid <= 1'b0;
    endtask

    // Directed cases under reset register values.
    task automatic test_directed();
        item_t it;
        for (int i = 0; i < PAT_LEN; i++) begin
            pat_a[i] = $urandom;
            pat_b[i] = ~pat_a[i];
        end
        send_frame(0, 4, 1'b1, 1'b0, 0);
        send_read(0, 1'b0);
        send_read(5, 1'b0);
        send_read(FB, 1'b0);
        send_read(2047, 1'b0);
        send_frame(0, 4, 1'b1, 1'b0, 10);
        // Full frame of ones plus bytes past the frame size, hinted: starts grayscale.
        for (int i = 0; i < FB + 2; i++) begin
            it = rand_item();
            it.mode = MODE_FRAME;
            it.pix = 8'hFF;
            it.fe = (i == FB + 1);
            it.on = 1'b1;
            it.hint = 1'b1;
            it.t = 20;
            send_item(it);
        end
        send_read(FB - 1, 1'b1);
        send_read(FB - 1, 1'b0);
        send_read(0, 1'b1);
        send_tick(20);
        send_tick(5);
        send_tick(20 + 750001);
        it = rand_item();
        it.mode = 2'd3;
        send_item(it);
        send_read(3, 1'b0);
        send_frame(3, 2, 1'b0, 1'b0, 30);
        send_frame(3, 3, 1'b1, 1'b1, 40);
        send_frame(1, 3, 1'b1, 1'b1, 15);
        send_frame(4, 1, 1'b1, 1'b0, 48'hFFFF_FFFF_FFFF);
        send_read(1, 1'b0);
    endtask

    // Random traffic: mostly A/B alternations with random timing, plus noise.
    task automatic test_random(input int n_items);
        int stop_at, len, r;
        bit toggle;
        stop_at = items_sent + n_items;
        len = $urandom_range(1, PAT_LEN);
        for (int i = 0; i < PAT_LEN; i++) begin
            pat_a[i] = $urandom;
            pat_b[i] = $urandom;
        end
        toggle = 1'b0;
        while (items_sent < stop_at) begin
            r = $urandom_range(0, 9);
            if ($urandom_range(0, 15) == 0) cur_t = {$urandom, $urandom} & 48'hFFFF_FFFF_FFFF;
            else cur_t += $urandom_range(0, 45000);
            cur_t &= 48'hFFFF_FFFF_FFFF;
            if (r <= 5) begin
                send_frame($urandom_range(0, 4) == 0 ? 2 : int'(toggle), len,
                           $urandom_range(0, 15) != 0, $urandom_range(0, 3) == 0, cur_t);
                toggle = ~toggle;
            end else if (r <= 7) begin
                repeat ($urandom_range(1, 4))
                    send_read($urandom_range(0, 1) ? $urandom_range(0, len) : $urandom_range(0, 2047),
                              $urandom);
            end else if (r == 8) begin
                cur_t += $urandom_range(0, 1000000);
                send_tick(cur_t & 48'hFFFF_FFFF_FFFF);
            end else if ($urandom_range(0, 3) == 0) begin
                send_frame(3, $urandom_range(0, 30) == 0 ? FB : $urandom_range(1, 40),
                           $urandom, $urandom, cur_t);
            end else begin
                send_item(rand_item());
            end
        end
    endtask

    // Output ready with random stall bursts.
    int stall_left;
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            out_if.ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 11);
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= 1'b1;
        end
    end

    // Result checking and idle watchdog.
    int idle_cycles;
    always @(posedge i_clk) begin
        status_t e;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (status_q.size() == 0) begin
                errors++;
                if (mismatches < 10)
                    $display("unexpected beat: kind=%0d byte=%0h", out_if.kind, out_if.read_byte);
                mismatches++;
            end else begin
                e = status_q.pop_front();
                if (out_if.kind !== e.kind || out_if.read_byte !== e.rbyte ||
                    out_if.gray_active !== e.gray || out_if.expired !== e.expd ||
                    out_if.adjacent_bits !== e.adj) begin
                    errors++;
                    if (mismatches < 10)
                        $display("mismatch: exp kind=%0d byte=%0h gray=%0b exp=%0b adj=%0d act kind=%0d byte=%0h gray=%0b exp=%0b adj=%0d",
                                 e.kind, e.rbyte, e.gray, e.expd, e.adj, out_if.kind,
                                 out_if.read_byte, out_if.gray_active, out_if.expired,
                                 out_if.adjacent_bits);
                    mismatches++;
                end
            end
        end
        if (!i_rst_n || (out_if.valid && out_if.ready) || (in_if.valid && in_if.ready) ||
            cfg_if.valid)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        in_if.valid = 1'b0;
        in_if.mode = MODE_FRAME;
        in_if.pixel_byte = '0;
        in_if.frame_end = 1'b0;
        in_if.display_on = 1'b0;
        in_if.gray_hint = 1'b0;
        in_if.time_us = '0;
        in_if.read_index = '0;
        in_if.read_alternate = 1'b0;
        out_if.ready = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.index = '0;
        cfg_if.data = '0;
        stall_left = 0;
        idle_cycles = 0;
        errors = 0;
        mismatches = 0;
        items_sent = 0;
        quiet = 1'b0;
        cur_t = 1000;
        cfg_min_plane = MIN_PLANE_RST;
        cfg_scene_cut = SCENE_CUT_RST;
        cfg_margin = MARGIN_RST;
        cfg_pair_max = PAIR_MAX_RST;
        cfg_cycle_max = CYCLE_MAX_RST;
        cfg_hold = HOLD_RST;
        for (int i = 0; i < FB; i++) begin
            fr_cur[i] = 0; fr_prev[i] = 0; fr_old[i] = 0; pl_a[i] = 0; pl_b[i] = 0;
            pend_pri[i] = 0; pend_alt[i] = 0;
        end
        pos = 0;
        cnt = '{0, 0, 0, 0};
        {prev_v, old_v, gray_on, reseed, latest_b, ev_v} = '0;
        prev_t = 0; old_t = 0; ev_t = 0;
        pri_ok = 1'b0; alt_ok = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        set_config(16, 60, 8, 70000, 140000, 750000);
        test_random(180);
        set_config(0, 0, 0, 0, 0, 0);
        test_random(90);
        set_config(8704, 8704, 8704, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
        test_random(90);
        set_config($urandom_range(1, 40), $urandom_range(10, 120), $urandom_range(0, 40),
                   $urandom_range(20000, 90000), $urandom_range(40000, 180000),
                   $urandom_range(50000, 900000));
        test_random(180);
        set_config(8, 30, 20, 60000, 120000, 200000);
        quiet = 1'b1;
        test_random(120);

        wait_idle();
        if (errors == 0) $display("CHECK OK");
        else $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== temporal_grayscale_frame_detector_core.f =====
+incdir+rtl
rtl/tgfd_pkg.sv
rtl/tgfd_if.sv
rtl/tgfd_ram.sv
rtl/temporal_grayscale_frame_detector_core.sv
dv/testbench.sv
